>>> src/tcw_pkg.sv
package tcw_pkg;

  localparam int KIND_W    = 2;
  localparam int CHAR_W    = 8;
  localparam int ADDR_W    = 11;
  localparam int COL_W     = 7;
  localparam int ROW_W     = 5;
  localparam int COLOUR_W  = 4;
  localparam int CELL_W    = 16;
  localparam int POS_W     = ROW_W + COL_W + 1;
  localparam int CFG_IDX_W = 1;

  localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_HOME  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd3;

  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0a;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam logic [CHAR_W-1:0]   DEFAULT_ATTR = 8'h0f;
  localparam logic [COLOUR_W-1:0] FORE_RESET   = 4'hf;
  localparam logic [COLOUR_W-1:0] BACK_RESET   = 4'h0;

  localparam logic [CFG_IDX_W-1:0] CFG_FORE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACK = 1'b1;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CHAR_W-1:0] char_code;
    logic [ADDR_W-1:0] cell_addr;
    logic              end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] cursor_pos;
    logic [CHAR_W-1:0] read_char;
    logic [CHAR_W-1:0] read_attr;
  } out_item_t;

  typedef struct packed {
    logic [COLOUR_W-1:0] back;
    logic [COLOUR_W-1:0] fore;
  } colour_t;

endpackage

>>> src/tcw_in_if.sv
interface tcw_in_if;
  logic               valid;
  logic               ready;
  tcw_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/tcw_out_if.sv
interface tcw_out_if;
  logic                valid;
  logic                ready;
  tcw_pkg::out_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/tcw_ram.sv
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> src/tcw_ctrl.sv
module tcw_ctrl #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  localparam int CELLS  = COLUMNS * ROWS,
  localparam int AW     = $clog2(CELLS)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tcw_pkg::colour_t           colour,
  input  logic                       in_vld,
  output logic                       in_rdy,
  input  tcw_pkg::in_item_t          in_item,
  output logic                       res_vld,
  input  logic                       res_rdy,
  output tcw_pkg::out_item_t         res_item,
  output logic                       ram_we,
  output logic [AW-1:0]              ram_waddr,
  output logic [tcw_pkg::CELL_W-1:0] ram_wdata,
  output logic [AW-1:0]              ram_raddr,
  input  logic [tcw_pkg::CELL_W-1:0] ram_rdata
);

  localparam int CW = AW + 1;

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_DRAW = 3'd2;
  localparam logic [2:0] S_NL   = 3'd3;
  localparam logic [2:0] S_COPY = 3'd4;
  localparam logic [2:0] S_FILL = 3'd5;
  localparam logic [2:0] S_RDW  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]                    state_r, state_nxt;
  logic [tcw_pkg::COL_W-1:0]     col_r, col_nxt;
  logic [tcw_pkg::ROW_W-1:0]     row_r, row_nxt;
  logic [tcw_pkg::ADDR_W-1:0]    cursor_r, cursor_nxt;
  logic [tcw_pkg::KIND_W-1:0]    kind_r, kind_nxt;
  logic [tcw_pkg::CHAR_W-1:0]    char_r, char_nxt;
  logic                          tab_r, tab_nxt;
  logic                          more_r, more_nxt;
  logic                          oor_r, oor_nxt;
  logic [tcw_pkg::CHAR_W-1:0]    rc_r, rc_nxt;
  logic [tcw_pkg::CHAR_W-1:0]    ra_r, ra_nxt;
  logic [CW-1:0]                 src_r, src_nxt;
  logic                          pend_r, pend_nxt;
  logic [AW-1:0]                 pend_addr_r, pend_addr_nxt;
  logic [CW-1:0]                 ptr_r, ptr_nxt;
  logic [CW-1:0]                 end_r, end_nxt;

  logic [tcw_pkg::POS_W-1:0]     pos;
  logic [tcw_pkg::CHAR_W-1:0]    attr;
  logic [tcw_pkg::CELL_W-1:0]    blank;
  logic                          last_col;
  logic                          last_row;
  logic [tcw_pkg::ADDR_W-1:0]    cursor_new;

  assign pos = tcw_pkg::POS_W'(row_r) * tcw_pkg::POS_W'(COLUMNS)
             + tcw_pkg::POS_W'(col_r);
  assign attr     = {colour.back, colour.fore};
  assign blank    = {attr, tcw_pkg::CH_SPACE};
  assign last_col = (col_r >= tcw_pkg::COL_W'(COLUMNS - 1));
  assign last_row = (row_r >= tcw_pkg::ROW_W'(ROWS - 1));

  always_comb begin
    case (kind_r)
      tcw_pkg::KIND_PUT:   cursor_new = pos[tcw_pkg::ADDR_W-1:0];
      tcw_pkg::KIND_READ:  cursor_new = cursor_r;
      default:             cursor_new = '0;
    endcase
  end

  assign res_item.cursor_pos = cursor_new;
  assign res_item.read_char  = rc_r;
  assign res_item.read_attr  = ra_r;

  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    cursor_nxt    = cursor_r;
    kind_nxt      = kind_r;
    char_nxt      = char_r;
    tab_nxt       = tab_r;
    more_nxt      = more_r;
    oor_nxt       = oor_r;
    rc_nxt        = rc_r;
    ra_nxt        = ra_r;
    src_nxt       = src_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    ptr_nxt       = ptr_r;
    end_nxt       = end_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_raddr     = AW'(in_item.cell_addr);
    in_rdy        = (state_r == S_IDLE);
    res_vld       = 1'b0;

    unique case (state_r)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_r[AW-1:0];
        ram_wdata = {tcw_pkg::DEFAULT_ATTR, tcw_pkg::CH_SPACE};
        if (ptr_r == CW'(CELLS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_vld) begin
          kind_nxt = in_item.kind;
          tab_nxt  = 1'b0;
          more_nxt = 1'b0;
          rc_nxt   = '0;
          ra_nxt   = '0;
          oor_nxt  = !(int'(in_item.cell_addr) < CELLS);
          unique case (in_item.kind)
            tcw_pkg::KIND_PUT: begin
              if (in_item.char_code == tcw_pkg::CH_LF ||
                  in_item.char_code == tcw_pkg::CH_CR) begin
                state_nxt = S_NL;
              end else if (in_item.char_code == tcw_pkg::CH_TAB) begin
                char_nxt  = tcw_pkg::CH_SPACE;
                tab_nxt   = 1'b1;
                state_nxt = S_DRAW;
              end else begin
                char_nxt  = in_item.char_code;
                state_nxt = S_DRAW;
              end
            end
            tcw_pkg::KIND_CLEAR: begin
              col_nxt   = '0;
              row_nxt   = '0;
              ptr_nxt   = '0;
              end_nxt   = CW'(CELLS - 1);
              state_nxt = S_FILL;
            end
            tcw_pkg::KIND_HOME: begin
              row_nxt   = '0;
              ptr_nxt   = '0;
              end_nxt   = CW'(COLUMNS - 1);
              state_nxt = S_FILL;
            end
            default: begin
              state_nxt = S_RDW;
            end
          endcase
        end
      end
      S_DRAW: begin
        ram_we    = 1'b1;
        ram_waddr = pos[AW-1:0];
        ram_wdata = {attr, char_r};
        tab_nxt   = 1'b0;
        more_nxt  = tab_r;
        if (last_col) begin
          state_nxt = S_NL;
        end else begin
          col_nxt   = col_r + 1'b1;
          state_nxt = tab_r ? S_DRAW : S_DONE;
        end
      end
      S_NL: begin
        col_nxt = '0;
        if (last_row) begin
          src_nxt   = CW'(COLUMNS);
          pend_nxt  = 1'b0;
          state_nxt = S_COPY;
        end else begin
          row_nxt   = row_r + 1'b1;
          more_nxt  = 1'b0;
          state_nxt = more_r ? S_DRAW : S_DONE;
        end
      end
      S_COPY: begin
        ram_raddr = src_r[AW-1:0];
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = pend_addr_r;
          ram_wdata = ram_rdata;
        end
        if (src_r != CW'(CELLS)) begin
          pend_nxt      = 1'b1;
          pend_addr_nxt = AW'(src_r - CW'(COLUMNS));
          src_nxt       = src_r + 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          ptr_nxt   = CW'(CELLS - COLUMNS);
          end_nxt   = CW'(CELLS - 1);
          state_nxt = S_FILL;
        end
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_r[AW-1:0];
        ram_wdata = blank;
        if (ptr_r == end_r) begin
          more_nxt  = 1'b0;
          state_nxt = more_r ? S_DRAW : S_DONE;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      S_RDW: begin
        rc_nxt    = oor_r ? '0 : ram_rdata[tcw_pkg::CHAR_W-1:0];
        ra_nxt    = oor_r ? '0 : ram_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
        state_nxt = S_DONE;
      end
      S_DONE: begin
        res_vld = 1'b1;
        if (res_rdy) begin
          cursor_nxt = cursor_new;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_INIT;
      col_r    <= '0;
      row_r    <= '0;
      cursor_r <= '0;
      tab_r    <= 1'b0;
      more_r   <= 1'b0;
      pend_r   <= 1'b0;
      ptr_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      cursor_r <= cursor_nxt;
      tab_r    <= tab_nxt;
      more_r   <= more_nxt;
      pend_r   <= pend_nxt;
      ptr_r    <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    char_r      <= char_nxt;
    oor_r       <= oor_nxt;
    rc_r        <= rc_nxt;
    ra_r        <= ra_nxt;
    src_r       <= src_nxt;
    pend_addr_r <= pend_addr_nxt;
    end_r       <= end_nxt;
  end

endmodule

>>> src/text_console_writer.sv
// Character console over a COLUMNS x ROWS text cell store held in one RAM.
// Commands arrive on in_chan: put a character, clear the screen, blank the
// top row, or read one cell back. Every command gives exactly one word on
// out_chan carrying the cursor position and, for a read, the cell's bytes.
// The colour registers are written through cfg_we, cfg_idx and cfg_wdata;
// the user must write them only while the console is idle, which the block
// itself does not enforce. Blanked and drawn cells take their attribute.
// A scroll copies the store one cell per cycle through the RAM's read and
// write ports; a newline on the last row scrolls, and so does a character
// that wraps into a scroll. One command is in work at a time.
// After reset a clearing pass writes blank cells with the default attribute
// to the whole store, during which no command is taken.
// The result word sits in an output register; while the receiver stalls the
// console still takes the next command and holds its result until the
// register is free.
module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                              clk,
  input  logic                              rst_n,
  tcw_in_if.sink                            in_chan,
  tcw_out_if.source                         out_chan,
  input  logic                              cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [tcw_pkg::COLOUR_W-1:0]      cfg_wdata
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);

  tcw_pkg::colour_t            colour_r;
  logic                        out_vld_r;
  tcw_pkg::out_item_t          out_item_r;
  logic                        res_vld;
  logic                        res_rdy;
  tcw_pkg::out_item_t          res_item;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [tcw_pkg::CELL_W-1:0]  ram_wdata;
  logic [AW-1:0]               ram_raddr;
  logic [tcw_pkg::CELL_W-1:0]  ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      colour_r.fore <= tcw_pkg::FORE_RESET;
      colour_r.back <= tcw_pkg::BACK_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        tcw_pkg::CFG_FORE: colour_r.fore <= cfg_wdata;
        default:           colour_r.back <= cfg_wdata;
      endcase
    end
  end

  assign res_rdy = !out_vld_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_rdy) begin
      out_vld_r <= res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (res_rdy && res_vld) begin
      out_item_r <= res_item;
    end
  end

  assign out_chan.valid = out_vld_r;
  assign out_chan.data  = out_item_r;

  tcw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .colour    (colour_r),
    .in_vld    (in_chan.valid),
    .in_rdy    (in_chan.ready),
    .in_item   (in_chan.data),
    .res_vld   (res_vld),
    .res_rdy   (res_rdy),
    .res_item  (res_item),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (CELLS)
  ) u_cell_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

endmodule
